// ===== hw/rtl/psra_pkg.sv =====
// ----------------------------------------------------------------------------
// Paired statistics package
// Action codes, field widths, fixed-point constants, the result record and the
// sequencer and arithmetic unit types shared by the accumulator modules.
// ----------------------------------------------------------------------------
package psra_pkg;

	localparam int ACT_W     = 3;
	localparam int CNT_OUT_W = 16;
	localparam int MEAN_W    = 48;
	localparam int DEV_W     = 47;
	localparam int CORR_W    = 32;
	localparam int STATUS_W  = 6;

	localparam int FRAC_BITS  = 16;
	localparam int DEV_SHIFT  = 32;
	localparam int CORR_SHIFT = 60;
	localparam logic [CORR_W-1:0] CORR_ONE = 32'h4000_0000;

	localparam logic [ACT_W-1:0] ACT_ADD   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_REM   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd2;
	localparam logic [ACT_W-1:0] ACT_EST_Y = 3'd3;
	localparam logic [ACT_W-1:0] ACT_EST_X = 3'd4;

	localparam int STAT_NO_MEAN = 0;
	localparam int STAT_NO_DEV  = 1;
	localparam int STAT_NO_REG  = 2;
	localparam int STAT_NO_CORR = 3;
	localparam int STAT_NO_EST  = 4;
	localparam int STAT_REFUSED = 5;

	typedef struct packed {
		logic [CNT_OUT_W-1:0]     sample_count;
		logic signed [MEAN_W-1:0] mean_x;
		logic signed [MEAN_W-1:0] mean_y;
		logic [DEV_W-1:0]         sample_dev_x;
		logic [DEV_W-1:0]         pop_dev_x;
		logic [DEV_W-1:0]         sample_dev_y;
		logic [DEV_W-1:0]         pop_dev_y;
		logic signed [CORR_W-1:0] correlation;
		logic signed [MEAN_W-1:0] slope;
		logic signed [MEAN_W-1:0] intercept;
		logic signed [MEAN_W-1:0] estimate;
		logic [STATUS_W-1:0]      status;
	} result_t;

	typedef enum logic [1:0] {
		UOP_MUL,
		UOP_DIV_RND,
		UOP_DIV_TRN,
		UOP_SQRT
	} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_cmd_t;

	typedef enum logic [2:0] {
		US_IDLE,
		US_MUL,
		US_DIV,
		US_SQRT,
		US_FIN
	} unit_state_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ISSUE,
		CS_WAIT,
		CS_HOLD
	} ctl_state_t;

	typedef enum logic [5:0] {
		STEP_SQX, STEP_SQY, STEP_PXY, STEP_APPLY,
		STEP_NSXX, STEP_SXSX, STEP_DXX,
		STEP_NSYY, STEP_SYSY, STEP_DYY,
		STEP_NSXY, STEP_SXSY, STEP_DXY,
		STEP_SYSXX, STEP_SXSXY, STEP_NB,
		STEP_MEANX, STEP_MEANY,
		STEP_NN1, STEP_N2,
		STEP_DXA, STEP_DXB, STEP_DXC, STEP_DXD,
		STEP_DYA, STEP_DYB, STEP_DYC, STEP_DYD,
		STEP_CA, STEP_CB, STEP_CC, STEP_CD,
		STEP_SLOPE, STEP_ICPT,
		STEP_EYA, STEP_EYB, STEP_EYC,
		STEP_EXA, STEP_EXB, STEP_EXC,
		STEP_END
	} step_t;

endpackage

// ===== hw/rtl/psra_in_if.sv =====
// ----------------------------------------------------------------------------
// Sample item channel
// Valid/ready channel that carries one action with its x and y samples.
// ----------------------------------------------------------------------------
interface psra_in_if
	import psra_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic [ACT_W-1:0]              action;
	logic signed [SAMPLE_BITS-1:0] x_value;
	logic signed [SAMPLE_BITS-1:0] y_value;

	modport source (output valid, action, x_value, y_value, input ready);
	modport sink (input valid, action, x_value, y_value, output ready);
endinterface

// ===== hw/rtl/psra_out_if.sv =====
// ----------------------------------------------------------------------------
// Statistics result channel
// Valid/ready channel that carries the count, moments, regression and status.
// ----------------------------------------------------------------------------
interface psra_out_if
	import psra_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [CNT_OUT_W-1:0]     sample_count;
	logic signed [MEAN_W-1:0] mean_x;
	logic signed [MEAN_W-1:0] mean_y;
	logic [DEV_W-1:0]         sample_dev_x;
	logic [DEV_W-1:0]         pop_dev_x;
	logic [DEV_W-1:0]         sample_dev_y;
	logic [DEV_W-1:0]         pop_dev_y;
	logic signed [CORR_W-1:0] correlation;
	logic signed [MEAN_W-1:0] slope;
	logic signed [MEAN_W-1:0] intercept;
	logic signed [MEAN_W-1:0] estimate;
	logic [STATUS_W-1:0]      status;

	modport source (output valid, sample_count, mean_x, mean_y, sample_dev_x, pop_dev_x,
		sample_dev_y, pop_dev_y, correlation, slope, intercept, estimate, status,
		input ready);
	modport sink (input valid, sample_count, mean_x, mean_y, sample_dev_x, pop_dev_x,
		sample_dev_y, pop_dev_y, correlation, slope, intercept, estimate, status,
		output ready);
endinterface

// ===== hw/rtl/psra_unit.sv =====
// ----------------------------------------------------------------------------
// Shared wide arithmetic unit
// Bit-serial signed multiply, restoring divide with optional rounding to
// nearest, and restoring integer square root over one wide word.
// ----------------------------------------------------------------------------
module psra_unit
	import psra_pkg::*;
#(
	parameter int W  = 196,
	parameter int MB = 66
) (
	input  logic                clk,
	input  logic                arst_n,
	input  unit_cmd_t           cmd,
	input  logic signed [W-1:0] opa,
	input  logic signed [W-1:0] opb,
	output logic                done,
	output logic signed [W-1:0] res
);
	localparam int H  = W / 2;
	localparam int CW = $clog2(W + 1);

	unit_state_t         state_q, state_d;
	unit_op_t            op_q;
	logic [CW-1:0]       cnt_q;
	logic [W-1:0]        acc_q, src_q, aux_q;
	logic                neg_q, rnd_q, done_q;
	logic signed [W-1:0] res_q;
	logic [W-1:0]        abs_a, abs_b, div_trial, sq_trial, sq_test, mag;
	logic                div_ge, sq_ge;

	assign abs_a     = opa[W-1] ? W'(-opa) : W'(opa);
	assign abs_b     = opb[W-1] ? W'(-opb) : W'(opb);
	assign div_trial = {acc_q[W-2:0], src_q[W-1]};
	assign div_ge    = div_trial >= aux_q;
	assign sq_trial  = {acc_q[W-3:0], src_q[W-1:W-2]};
	assign sq_test   = {aux_q[W-3:0], 2'b01};
	assign sq_ge     = sq_trial >= sq_test;

	always_comb begin
		case (op_q)
			UOP_MUL: mag = acc_q;
			UOP_SQRT: mag = aux_q;
			default: mag = src_q + W'(rnd_q && ({acc_q[W-2:0], 1'b0} >= aux_q));
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			US_IDLE: begin
				if (cmd.start) begin
					case (cmd.op)
						UOP_MUL: state_d = US_MUL;
						UOP_SQRT: state_d = US_SQRT;
						default: state_d = US_DIV;
					endcase
				end
			end
			US_MUL, US_DIV, US_SQRT: begin
				if (cnt_q == '0) state_d = US_FIN;
			end
			US_FIN: state_d = US_IDLE;
			default: state_d = US_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= US_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == US_FIN;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			US_IDLE: begin
				if (cmd.start) begin
					acc_q <= '0;
					op_q  <= cmd.op;
					rnd_q <= cmd.op == UOP_DIV_RND;
					case (cmd.op)
						UOP_MUL: begin
							src_q <= abs_a;
							aux_q <= abs_b;
							neg_q <= opa[W-1] ^ opb[W-1];
							cnt_q <= CW'(MB - 1);
						end
						UOP_SQRT: begin
							src_q <= opa;
							aux_q <= '0;
							neg_q <= 1'b0;
							cnt_q <= CW'(H - 1);
						end
						default: begin
							src_q <= abs_a;
							aux_q <= abs_b;
							neg_q <= opa[W-1] ^ opb[W-1];
							cnt_q <= CW'(W - 1);
						end
					endcase
				end
			end
			US_MUL: begin
				acc_q <= acc_q + (aux_q[0] ? src_q : '0);
				src_q <= {src_q[W-2:0], 1'b0};
				aux_q <= {1'b0, aux_q[W-1:1]};
				cnt_q <= cnt_q - 1'b1;
			end
			US_DIV: begin
				acc_q <= div_ge ? div_trial - aux_q : div_trial;
				src_q <= {src_q[W-2:0], div_ge};
				cnt_q <= cnt_q - 1'b1;
			end
			US_SQRT: begin
				acc_q <= sq_ge ? sq_trial - sq_test : sq_trial;
				aux_q <= {aux_q[W-2:0], sq_ge};
				src_q <= {src_q[W-3:0], 2'b00};
				cnt_q <= cnt_q - 1'b1;
			end
			US_FIN: res_q <= neg_q ? -$signed(mag) : $signed(mag);
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> state_q == US_IDLE)
		else $error("Unit started while busy.");
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == US_IDLE && $past(state_q) == US_FIN)
		else $error("Unit done without a finishing cycle.");
	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == US_MUL |-> cnt_q < CW'(MB))
		else $error("Multiply count out of range.");
endmodule

// ===== hw/rtl/paired_stats_regression_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// Paired statistics and linear regression accumulator
// Keeps exact running sums of sample pairs and reports moments, deviations,
// correlation and least squares fit for every item, plus an estimate for
// the estimate actions.
// Each item is taken only while the block is idle and runs through a fixed
// sequence of forty steps on one shared bit-serial unit. An empty or
// single-pair sum still forms the spread products. The result sits in an
// output register, so the next item can be taken while it waits for its
// transfer.
// ----------------------------------------------------------------------------
module paired_stats_regression_accumulator_core
	import psra_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 16
) (
	input logic        clk,
	input logic        arst_n,
	psra_in_if.sink    item,
	psra_out_if.source result
);
	localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
	localparam int SQ_W  = 2 * SAMPLE_BITS + COUNT_BITS;
	localparam int DW    = 2 * SAMPLE_BITS + 2 * COUNT_BITS + 2;
	localparam int W     = 2 * DW + 62;

	ctl_state_t state_q, state_d;
	step_t      step_q;
	logic       res_valid_q;

	logic [COUNT_BITS-1:0]   pair_count_q;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
	logic signed [SQ_W-1:0]  sum_xx_q, sum_yy_q, sum_xy_q;

	logic [ACT_W-1:0]              act_q;
	logic signed [SAMPLE_BITS-1:0] x_q, y_q;
	logic signed [W-1:0]           t0_q, t1_q, t2_q, dxx_q, dyy_q, dxy_q, nb_q, nn1_q, n2_q;
	result_t                       work_q, out_q;

	logic signed [W-1:0] x_w, y_w, sx_w, sy_w, sxx_w, syy_w, sxy_w, n_w, nm1_w;
	logic signed [W-1:0] abs_dxx, abs_dyy, a_sel, b_sel, u_res;
	unit_cmd_t           u_cmd;
	unit_op_t            u_op;
	logic                u_done, accept, issue, advance, load_out;
	logic                step_run, step_local;
	logic [STATUS_W-1:0] stat_set;
	logic                is_est, upd_ok, refused, n_ge2, dxx_zero, dxy_zero, dxx_pos, dyy_pos;
	logic                reg_ok;

	function automatic logic signed [MEAN_W-1:0] sat_s(input logic signed [W-1:0] v);
		logic [W-MEAN_W:0] hi;
		hi = v[W-1:MEAN_W-1];
		if (hi == '0 || hi == '1) return v[MEAN_W-1:0];
		else if (v[W-1]) return {1'b1, {(MEAN_W - 1){1'b0}}};
		else return {1'b0, {(MEAN_W - 1){1'b1}}};
	endfunction

	function automatic logic [DEV_W-1:0] sat_u(input logic signed [W-1:0] v);
		if (|v[W-1:DEV_W]) return '1;
		else return v[DEV_W-1:0];
	endfunction

	function automatic logic signed [CORR_W-1:0] corr_of(input logic signed [W-1:0] v,
			input logic neg);
		logic [CORR_W-1:0] rq;
		rq = ($unsigned(v) > W'(CORR_ONE)) ? CORR_ONE : v[CORR_W-1:0];
		return neg ? -$signed(rq) : $signed(rq);
	endfunction

	assign x_w     = {{(W - SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};
	assign y_w     = {{(W - SAMPLE_BITS){y_q[SAMPLE_BITS-1]}}, y_q};
	assign sx_w    = {{(W - SUM_W){sum_x_q[SUM_W-1]}}, sum_x_q};
	assign sy_w    = {{(W - SUM_W){sum_y_q[SUM_W-1]}}, sum_y_q};
	assign sxx_w   = {{(W - SQ_W){sum_xx_q[SQ_W-1]}}, sum_xx_q};
	assign syy_w   = {{(W - SQ_W){sum_yy_q[SQ_W-1]}}, sum_yy_q};
	assign sxy_w   = {{(W - SQ_W){sum_xy_q[SQ_W-1]}}, sum_xy_q};
	assign n_w     = {{(W - COUNT_BITS){1'b0}}, pair_count_q};
	assign nm1_w   = n_w - W'(1);
	assign abs_dxx = dxx_q[W-1] ? -dxx_q : dxx_q;
	assign abs_dyy = dyy_q[W-1] ? -dyy_q : dyy_q;

	assign is_est   = act_q == ACT_EST_Y || act_q == ACT_EST_X;
	assign upd_ok   = (act_q == ACT_ADD && pair_count_q != '1) ||
		(act_q == ACT_REM && pair_count_q != '0);
	assign refused  = (act_q == ACT_ADD || act_q == ACT_REM) && !upd_ok;
	assign n_ge2    = pair_count_q > COUNT_BITS'(1);
	assign dxx_zero = dxx_q == '0;
	assign dxy_zero = dxy_q == '0;
	assign dxx_pos  = !dxx_q[W-1] && !dxx_zero;
	assign dyy_pos  = !dyy_q[W-1] && dyy_q != '0;
	assign reg_ok   = n_ge2 && !dxx_zero;

	always_comb begin
		step_run   = 1'b1;
		step_local = 1'b0;
		stat_set   = '0;
		u_op       = UOP_MUL;
		a_sel      = t0_q;
		b_sel      = t1_q;
		case (step_q)
			STEP_SQX: begin
				step_run = upd_ok;
				a_sel = x_w;
				b_sel = x_w;
			end
			STEP_SQY: begin
				step_run = upd_ok;
				a_sel = y_w;
				b_sel = y_w;
			end
			STEP_PXY: begin
				step_run = upd_ok;
				a_sel = x_w;
				b_sel = y_w;
			end
			STEP_APPLY: begin
				step_local = 1'b1;
				stat_set[STAT_REFUSED] = refused;
			end
			STEP_NSXX: begin
				a_sel = sxx_w;
				b_sel = n_w;
			end
			STEP_SXSX: begin
				a_sel = sx_w;
				b_sel = sx_w;
			end
			STEP_NSYY: begin
				a_sel = syy_w;
				b_sel = n_w;
			end
			STEP_SYSY: begin
				a_sel = sy_w;
				b_sel = sy_w;
			end
			STEP_NSXY: begin
				a_sel = sxy_w;
				b_sel = n_w;
			end
			STEP_SXSY: begin
				a_sel = sx_w;
				b_sel = sy_w;
			end
			STEP_SYSXX: begin
				a_sel = sxx_w;
				b_sel = sy_w;
			end
			STEP_SXSXY: begin
				a_sel = sxy_w;
				b_sel = sx_w;
			end
			STEP_DXX, STEP_DYY, STEP_DXY, STEP_NB, STEP_EYB, STEP_EXB: begin
				step_local = 1'b1;
				step_run = (step_q == STEP_EYB) ? reg_ok && act_q == ACT_EST_Y :
					(step_q == STEP_EXB) ? reg_ok && act_q == ACT_EST_X && !dxy_zero : 1'b1;
			end
			STEP_MEANX, STEP_MEANY: begin
				step_run = pair_count_q != '0;
				stat_set[STAT_NO_MEAN] = pair_count_q == '0;
				u_op = UOP_DIV_RND;
				a_sel = ((step_q == STEP_MEANX) ? sx_w : sy_w) <<< FRAC_BITS;
				b_sel = n_w;
			end
			STEP_NN1: begin
				step_run = n_ge2;
				stat_set[STAT_NO_DEV] = !n_ge2;
				stat_set[STAT_NO_REG] = !n_ge2;
				stat_set[STAT_NO_CORR] = !n_ge2;
				stat_set[STAT_NO_EST] = !n_ge2 && is_est;
				a_sel = n_w;
				b_sel = nm1_w;
			end
			STEP_N2: begin
				step_run = n_ge2;
				a_sel = n_w;
				b_sel = n_w;
			end
			STEP_DXA, STEP_DXC, STEP_DYA, STEP_DYC: begin
				step_run = n_ge2;
				u_op = UOP_DIV_TRN;
				a_sel = ((step_q == STEP_DXA || step_q == STEP_DXC) ? abs_dxx : abs_dyy)
					<<< DEV_SHIFT;
				b_sel = (step_q == STEP_DXA || step_q == STEP_DYA) ? nn1_q : n2_q;
			end
			STEP_DXB, STEP_DXD, STEP_DYB, STEP_DYD: begin
				step_run = n_ge2;
				u_op = UOP_SQRT;
			end
			STEP_CA: begin
				step_run = n_ge2 && dxx_pos && dyy_pos;
				stat_set[STAT_NO_CORR] = n_ge2 && !(dxx_pos && dyy_pos);
				a_sel = dxy_q;
				b_sel = dxy_q;
			end
			STEP_CB: begin
				step_run = n_ge2 && dxx_pos && dyy_pos;
				a_sel = dxx_q;
				b_sel = dyy_q;
			end
			STEP_CC: begin
				step_run = n_ge2 && dxx_pos && dyy_pos;
				u_op = UOP_DIV_TRN;
				a_sel = t0_q <<< CORR_SHIFT;
			end
			STEP_CD: begin
				step_run = n_ge2 && dxx_pos && dyy_pos;
				u_op = UOP_SQRT;
			end
			STEP_SLOPE: begin
				step_run = reg_ok;
				stat_set[STAT_NO_REG] = n_ge2 && dxx_zero;
				stat_set[STAT_NO_EST] = n_ge2 && dxx_zero && is_est;
				u_op = UOP_DIV_RND;
				a_sel = dxy_q <<< FRAC_BITS;
				b_sel = dxx_q;
			end
			STEP_ICPT: begin
				step_run = reg_ok;
				u_op = UOP_DIV_RND;
				a_sel = nb_q <<< FRAC_BITS;
				b_sel = dxx_q;
			end
			STEP_EYA: begin
				step_run = reg_ok && act_q == ACT_EST_Y;
				a_sel = dxy_q;
				b_sel = x_w;
			end
			STEP_EYC: begin
				step_run = reg_ok && act_q == ACT_EST_Y;
				u_op = UOP_DIV_RND;
				a_sel = t0_q <<< FRAC_BITS;
				b_sel = dxx_q;
			end
			STEP_EXA: begin
				step_run = reg_ok && act_q == ACT_EST_X && !dxy_zero;
				stat_set[STAT_NO_EST] = reg_ok && act_q == ACT_EST_X && dxy_zero;
				a_sel = dxx_q;
				b_sel = y_w;
			end
			STEP_EXC: begin
				step_run = reg_ok && act_q == ACT_EST_X && !dxy_zero;
				u_op = UOP_DIV_RND;
				a_sel = t0_q <<< FRAC_BITS;
				b_sel = dxy_q;
			end
			default: step_run = 1'b0;
		endcase
	end

	assign accept   = item.valid && state_q == CS_IDLE;
	assign issue    = state_q == CS_ISSUE && step_q != STEP_END;
	assign advance  = (issue && (!step_run || step_local)) || (state_q == CS_WAIT && u_done);
	assign load_out = state_q == CS_HOLD && (!res_valid_q || result.ready);
	assign u_cmd.start = issue && step_run && !step_local;
	assign u_cmd.op    = u_op;

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (item.valid) state_d = CS_ISSUE;
			end
			CS_ISSUE: begin
				if (step_q == STEP_END) state_d = CS_HOLD;
				else if (step_run && !step_local) state_d = CS_WAIT;
			end
			CS_WAIT: begin
				if (u_done) state_d = CS_ISSUE;
			end
			CS_HOLD: begin
				if (!res_valid_q || result.ready) state_d = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= STEP_SQX;
			res_valid_q  <= 1'b0;
			pair_count_q <= '0;
			sum_x_q      <= '0;
			sum_y_q      <= '0;
			sum_xx_q     <= '0;
			sum_yy_q     <= '0;
			sum_xy_q     <= '0;
		end else begin
			if (accept) step_q <= STEP_SQX;
			else if (advance) step_q <= step_t'(step_q + 6'd1);
			if (load_out) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
			if (issue && step_q == STEP_APPLY) begin
				if (act_q == ACT_CLEAR) begin
					pair_count_q <= '0;
					sum_x_q      <= '0;
					sum_y_q      <= '0;
					sum_xx_q     <= '0;
					sum_yy_q     <= '0;
					sum_xy_q     <= '0;
				end else if (upd_ok && act_q == ACT_ADD) begin
					pair_count_q <= pair_count_q + 1'b1;
					sum_x_q      <= sum_x_q + x_w[SUM_W-1:0];
					sum_y_q      <= sum_y_q + y_w[SUM_W-1:0];
					sum_xx_q     <= sum_xx_q + t0_q[SQ_W-1:0];
					sum_yy_q     <= sum_yy_q + t1_q[SQ_W-1:0];
					sum_xy_q     <= sum_xy_q + t2_q[SQ_W-1:0];
				end else if (upd_ok) begin
					pair_count_q <= pair_count_q - 1'b1;
					sum_x_q      <= sum_x_q - x_w[SUM_W-1:0];
					sum_y_q      <= sum_y_q - y_w[SUM_W-1:0];
					sum_xx_q     <= sum_xx_q - t0_q[SQ_W-1:0];
					sum_yy_q     <= sum_yy_q - t1_q[SQ_W-1:0];
					sum_xy_q     <= sum_xy_q - t2_q[SQ_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= item.action;
			x_q    <= item.x_value;
			y_q    <= item.y_value;
			work_q <= '0;
		end else begin
			if (issue) work_q.status <= work_q.status | stat_set;
			if (issue && step_q == STEP_APPLY) begin
				work_q.sample_count <= CNT_OUT_W'(act_q == ACT_CLEAR ? '0 :
					upd_ok && act_q == ACT_ADD ? pair_count_q + 1'b1 :
					upd_ok ? pair_count_q - 1'b1 : pair_count_q);
			end
		end
		if (issue && step_run && step_local) begin
			case (step_q)
				STEP_DXX: dxx_q <= t0_q - t1_q;
				STEP_DYY: dyy_q <= t0_q - t1_q;
				STEP_DXY: dxy_q <= t0_q - t1_q;
				STEP_NB: nb_q <= t0_q - t1_q;
				STEP_EYB: t0_q <= t0_q + nb_q;
				STEP_EXB: t0_q <= t0_q - nb_q;
				default: ;
			endcase
		end
		if (state_q == CS_WAIT && u_done) begin
			case (step_q)
				STEP_SQX, STEP_NSXX, STEP_NSYY, STEP_NSXY, STEP_SYSXX, STEP_DXA, STEP_DXC,
				STEP_DYA, STEP_DYC, STEP_CA, STEP_CC, STEP_EYA, STEP_EXA: t0_q <= u_res;
				STEP_SQY, STEP_SXSX, STEP_SYSY, STEP_SXSY, STEP_SXSXY, STEP_CB: t1_q <= u_res;
				STEP_PXY: t2_q <= u_res;
				STEP_NN1: nn1_q <= u_res;
				STEP_N2: n2_q <= u_res;
				STEP_MEANX: work_q.mean_x <= sat_s(u_res);
				STEP_MEANY: work_q.mean_y <= sat_s(u_res);
				STEP_DXB: work_q.sample_dev_x <= sat_u(u_res);
				STEP_DXD: work_q.pop_dev_x <= sat_u(u_res);
				STEP_DYB: work_q.sample_dev_y <= sat_u(u_res);
				STEP_DYD: work_q.pop_dev_y <= sat_u(u_res);
				STEP_CD: work_q.correlation <= corr_of(u_res, dxy_q[W-1]);
				STEP_SLOPE: work_q.slope <= sat_s(u_res);
				STEP_ICPT: work_q.intercept <= sat_s(u_res);
				STEP_EYC, STEP_EXC: work_q.estimate <= sat_s(u_res);
				default: ;
			endcase
		end
		if (load_out) out_q <= work_q;
	end

	psra_unit #(
		.W  (W),
		.MB (DW)
	) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (u_cmd),
		.opa    (a_sel),
		.opb    (b_sel),
		.done   (u_done),
		.res    (u_res)
	);

	assign item.ready          = state_q == CS_IDLE;
	assign result.valid        = res_valid_q;
	assign result.sample_count = out_q.sample_count;
	assign result.mean_x       = out_q.mean_x;
	assign result.mean_y       = out_q.mean_y;
	assign result.sample_dev_x = out_q.sample_dev_x;
	assign result.pop_dev_x    = out_q.pop_dev_x;
	assign result.sample_dev_y = out_q.sample_dev_y;
	assign result.pop_dev_y    = out_q.pop_dev_y;
	assign result.correlation  = out_q.correlation;
	assign result.slope        = out_q.slope;
	assign result.intercept    = out_q.intercept;
	assign result.estimate     = out_q.estimate;
	assign result.status       = out_q.status;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> state_q == CS_WAIT)
		else $error("Unit result arrived outside a wait step.");
	a_est_flag: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !work_q.status[STAT_NO_EST] || act_q == ACT_EST_Y || act_q == ACT_EST_X)
		else $error("Estimate flag set for a non-estimate action.");
	a_refused_flag: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !work_q.status[STAT_REFUSED] || act_q == ACT_ADD || act_q == ACT_REM)
		else $error("Refused flag set for an action that updates nothing.");
	a_dev_order: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> work_q.pop_dev_x <= work_q.sample_dev_x &&
			work_q.pop_dev_y <= work_q.sample_dev_y)
		else $error("Population deviation above sample deviation.");
	a_corr_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> work_q.correlation <= $signed(CORR_ONE) &&
			work_q.correlation >= -$signed(CORR_ONE))
		else $error("Correlation outside plus or minus one.");
endmodule
